// ===== design/six_axis_sine_motion_generator_top_defines.svh =====
// Assertion macros shared by the motion generator checker.
`ifndef SIX_AXIS_SINE_MOTION_GENERATOR_TOP_DEFINES_SVH
`define SIX_AXIS_SINE_MOTION_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/smg_pkg.sv =====
// Types, codes and constants shared by the motion generator modules.
package smg_pkg;

   localparam logic [1:0] OP_SET      = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_DEFAULTS = 2'd2;

   localparam logic CSR_HEAVE_BIAS = 1'b0;
   localparam logic CSR_RUN_ENABLE = 1'b1;

   localparam logic [20:0] HEAVE_BIAS_RST = 21'd50855;
   localparam logic [15:0] FREQ_LIN_DEF   = 16'd819;
   localparam logic [15:0] FREQ_ANG_DEF   = 16'd614;
   localparam logic signed [15:0] PHASE_QTR = -16'sd16384;

   // floor(x / 25) for x below 2^21 is (x * MOD25_M26) >> 26.
   localparam logic [21:0] MOD25_M26 = 22'd2684355;

   typedef enum logic [2:0] {
      TS_IDLE,
      TS_PREP,
      TS_READ,
      TS_LOAD,
      TS_RUN,
      TS_PUT
   } top_state_type;

   typedef enum logic [4:0] {
      CS_IDLE,
      CS_MOD,
      CS_RED,
      CS_SEL,
      CS_DIV0,
      CS_DIV1,
      CS_ANG0,
      CS_ANG1,
      CS_AMP,
      CS_FOLD,
      CS_Z2,
      CS_POLY,
      CS_SINE,
      CS_MUL0,
      CS_Q,
      CS_VM,
      CS_OUT
   } calc_state_type;

   typedef struct packed {
      logic        [31:0] samp;
      logic signed [23:0] sphase;
      logic        [15:0] afreq;
      logic        [23:0] tamp;
      logic signed [15:0] tphase;
      logic        [15:0] tfreq;
      logic               angular;
      logic               heave;
      logic               n_le1;
      logic        [18:0] nm;
      logic signed [20:0] bias;
   } calc_req_type;

   typedef struct packed {
      logic        [31:0] samp;
      logic signed [23:0] sphase;
      logic        [15:0] afreq;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
   } calc_rsp_type;

   function automatic logic [15:0] def_freq(input int unsigned idx);
      return (idx < 3) ? FREQ_LIN_DEF : FREQ_ANG_DEF;
   endfunction

   function automatic logic signed [15:0] def_phase(input int unsigned idx);
      return (idx == 1 || idx == 4) ? PHASE_QTR : 16'sd0;
   endfunction

endpackage

// ===== design/smg_ram.sv =====
// Generic single-port-write, registered-read RAM.
module smg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/smg_axis_calc.sv =====
// Multi-cycle arithmetic for one axis: frequency switch, smoothing, sine and outputs.
module smg_axis_calc import smg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  calc_req_type req,
   output logic         done,
   output calc_rsp_type rsp
);

   localparam logic [31:0] AMP_MIN_LIN = 32'd8388;
   localparam logic [31:0] AMP_MIN_ANG = 32'd167;
   localparam logic signed [39:0] PHASE_OFS = 40'sd1677721600;
   localparam logic [14:0] DIV_HI    = 15'd20971;
   localparam logic [24:0] DIV_RECIP = 25'd21474837;
   localparam logic [27:0] ANG_A     = 28'd171798691;
   localparam logic [13:0] ANG_B     = 14'd10485;
   localparam logic [19:0] ANG_RECIP = 20'd671089;
   localparam logic [26:0] DEG2RAD   = 27'd74961321;
   localparam logic [22:0] TWOPI_Q20 = 23'd6588397;
   localparam logic [31:0] S_C1 = 32'd1686629713;
   localparam logic [31:0] S_C3 = 32'd693598668;
   localparam logic [31:0] S_C5 = 32'd85569306;
   localparam logic [31:0] S_C7 = 32'd5026995;
   localparam logic [31:0] S_C9 = 32'd172275;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   // Phase within the 4096 s frequency period: (x mod 409600) as {x/16384 mod 25, low bits}.
   function automatic logic [18:0] fold_tick(input logic [34:0] x);
      logic [42:0] pr;
      logic [16:0] qt;
      logic [4:0]  rem;
      pr  = 43'(x[34:14]) * 43'(MOD25_M26);
      qt  = pr[42:26];
      rem = 5'(x[34:14] - 21'(22'(qt) * 22'd25));
      return {rem, x[13:0]};
   endfunction

   function automatic logic [31:0] poly_coef(input logic [1:0] i);
      logic [31:0] c;
      case (i)
         2'd0:    c = S_C7;
         2'd1:    c = S_C5;
         2'd2:    c = S_C3;
         default: c = S_C1;
      endcase
      return c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
      logic signed [31:0] r;
      if (v > 39'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -39'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   calc_state_type state_ff, state_in;
   logic [34:0] xa_ff, xa_in, xt_ff, xt_in;
   logic [18:0] ra_ff, ra_in, rt_ff, rt_in, r_ff, r_in;
   logic [15:0] f_ff, f_in;
   logic [39:0] na_ff, na_in, np_ff, np_in;
   logic [33:0] hqa_ff, hqa_in, hqp_ff, hqp_in;
   logic [23:0] ya_ff, ya_in, yp_ff, yp_in;
   logic [31:0] samp_ff, samp_in;
   logic signed [23:0] sph_ff, sph_in;
   logic [31:0] base_ff, base_in, ang_ff, ang_in, amp_ff, amp_in;
   logic [18:0] yang_ff, yang_in;
   logic [30:0] z_ff, z_in, z2_ff, z2_in;
   logic        zneg_ff, zneg_in;
   logic [31:0] t_ff, t_in;
   logic [1:0]  pc_ff, pc_in;
   logic        cos_sel_ff, cos_sel_in;
   logic [30:0] sm_ff, sm_in, cm_ff, cm_in;
   logic        sneg_ff, sneg_in, cneg_ff, cneg_in;
   logic [29:0] pm_ff, pm_in;
   logic [32:0] p_ff, p_in;
   logic [40:0] q_ff, q_in;
   logic [36:0] vm_ff, vm_in;
   logic signed [31:0] pos_ff, pos_in, vel_ff, vel_in;
   logic        done_ff, done_in;

   logic               start_a, start_t, amp_low, do_switch;
   logic signed [39:0] nps;
   logic [37:0]        ua, up;
   logic [48:0]        pra, prp;
   logic [33:0]        qa, qp;
   logic [4:0]         ra_hi;
   logic [13:0]        ra_lo;
   logic [38:0]        pang;
   logic [31:0]        src;
   logic signed [33:0] s0, s1;
   logic [62:0]        ym;
   logic [30:0]        ymag;
   logic signed [34:0] pw;
   logic signed [38:0] vw;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      xa_ff <= xa_in;  xt_ff <= xt_in;
      ra_ff <= ra_in;  rt_ff <= rt_in;  r_ff <= r_in;  f_ff <= f_in;
      na_ff <= na_in;  np_ff <= np_in;
      hqa_ff <= hqa_in;  hqp_ff <= hqp_in;  ya_ff <= ya_in;  yp_ff <= yp_in;
      samp_ff <= samp_in;  sph_ff <= sph_in;
      base_ff <= base_in;  yang_ff <= yang_in;  ang_ff <= ang_in;  amp_ff <= amp_in;
      z_ff <= z_in;  zneg_ff <= zneg_in;  z2_ff <= z2_in;  t_ff <= t_in;  pc_ff <= pc_in;
      cos_sel_ff <= cos_sel_in;
      sm_ff <= sm_in;  sneg_ff <= sneg_in;  cm_ff <= cm_in;  cneg_ff <= cneg_in;
      pm_ff <= pm_in;  p_ff <= p_in;  q_ff <= q_in;  vm_ff <= vm_in;
      pos_ff <= pos_in;  vel_ff <= vel_in;
   end

   always_comb begin
      state_in = state_ff;
      xa_in = xa_ff;  xt_in = xt_ff;
      ra_in = ra_ff;  rt_in = rt_ff;  r_in = r_ff;  f_in = f_ff;
      na_in = na_ff;  np_in = np_ff;
      hqa_in = hqa_ff;  hqp_in = hqp_ff;  ya_in = ya_ff;  yp_in = yp_ff;
      samp_in = samp_ff;  sph_in = sph_ff;
      base_in = base_ff;  yang_in = yang_ff;  ang_in = ang_ff;  amp_in = amp_ff;
      z_in = z_ff;  zneg_in = zneg_ff;  z2_in = z2_ff;  t_in = t_ff;  pc_in = pc_ff;
      cos_sel_in = cos_sel_ff;
      sm_in = sm_ff;  sneg_in = sneg_ff;  cm_in = cm_ff;  cneg_in = cneg_ff;
      pm_in = pm_ff;  p_in = p_ff;  q_in = q_ff;  vm_in = vm_ff;
      pos_in = pos_ff;  vel_in = vel_ff;
      done_in = 1'b0;

      start_a   = (req.afreq == 16'd0) ? req.n_le1 : (ra_ff <= 19'(req.afreq));
      start_t   = (req.tfreq == 16'd0) ? req.n_le1 : (rt_ff <= 19'(req.tfreq));
      amp_low   = req.angular ? (req.samp <= AMP_MIN_ANG) : (req.samp <= AMP_MIN_LIN);
      do_switch = amp_low || (req.tfreq != req.afreq && start_a && start_t);
      nps = ($signed(40'(req.tphase)) <<< 8) + $signed(40'(req.sphase)) * 40'sd99
            + 40'sd50 + PHASE_OFS;
      ua  = na_ff[39:2];
      up  = np_ff[39:2];
      pra = 49'(ya_ff) * 49'(DIV_RECIP);
      prp = 49'(yp_ff) * 49'(DIV_RECIP);
      qa  = hqa_ff + 34'(pra[48:29]);
      qp  = hqp_ff + 34'(prp[48:29]);
      ra_hi = r_ff[18:14];
      ra_lo = r_ff[13:0];
      pang  = 39'(yang_ff) * 39'(ANG_RECIP);
      src   = cos_sel_ff ? (ang_ff + 32'h4000_0000) : ang_ff;
      s0    = 34'($signed(src));
      if (s0 > 34'sd1073741824) begin
         s1 = 34'sd2147483648 - s0;
      end else if (s0 < -34'sd1073741824) begin
         s1 = -34'sd2147483648 - s0;
      end else begin
         s1 = s0;
      end
      ym   = (63'(z_ff) * 63'(t_ff)) >> 30;
      ymag = (ym > 63'(ONE_Q30)) ? ONE_Q30 : 31'(ym);
      pw   = sneg_ff ? -$signed(35'(pm_ff)) : $signed(35'(pm_ff));
      if (req.heave) begin
         pw = pw + 35'(req.bias);
      end
      vw   = cneg_ff ? -$signed(39'(vm_ff)) : $signed(39'(vm_ff));

      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               state_in = CS_MOD;
            end
         end
         CS_MOD: begin
            xa_in    = 35'(req.nm) * 35'(req.afreq);
            xt_in    = 35'(req.nm) * 35'(req.tfreq);
            state_in = CS_RED;
         end
         CS_RED: begin
            ra_in    = fold_tick(xa_ff);
            rt_in    = fold_tick(xt_ff);
            state_in = CS_SEL;
         end
         CS_SEL: begin
            f_in     = do_switch ? req.tfreq : req.afreq;
            r_in     = do_switch ? rt_ff : ra_ff;
            na_in    = (40'(req.tamp) << 8) + 40'(req.samp) * 40'd99 + 40'd50;
            np_in    = 40'(nps);
            state_in = CS_DIV0;
         end
         CS_DIV0: begin
            // Division by 100: quarter first, then split 25 across 2^19.
            hqa_in   = 34'(ua[37:19]) * 34'(DIV_HI);
            hqp_in   = 34'(up[37:19]) * 34'(DIV_HI);
            ya_in    = 24'(24'(ua[37:19]) * 24'd13 + 24'(ua[18:0]));
            yp_in    = 24'(24'(up[37:19]) * 24'd13 + 24'(up[18:0]));
            state_in = CS_DIV1;
         end
         CS_DIV1: begin
            samp_in  = qa[31:0];
            sph_in   = 24'(qp - 34'd16777216);
            state_in = CS_ANG0;
         end
         CS_ANG0: begin
            base_in  = 32'(32'(ra_hi) * 32'(ANG_A) + 32'(ra_lo) * 32'(ANG_B));
            yang_in  = 19'(19'(ra_hi) * 19'd21 + 19'(ra_lo) * 19'd19);
            state_in = CS_ANG1;
         end
         CS_ANG1: begin
            ang_in     = base_ff + 32'(pang[38:24]) + {sph_ff, 8'h00};
            cos_sel_in = 1'b0;
            state_in   = CS_AMP;
         end
         CS_AMP: begin
            amp_in   = req.angular
                       ? 32'((64'(samp_ff) * 64'(DEG2RAD) + 64'h8000_0000) >> 32)
                       : samp_ff;
            state_in = CS_FOLD;
         end
         CS_FOLD: begin
            zneg_in  = (s1 < 34'sd0);
            z_in     = 31'((s1 < 34'sd0) ? -s1 : s1);
            state_in = CS_Z2;
         end
         CS_Z2: begin
            z2_in    = 31'((62'(z_ff) * 62'(z_ff)) >> 30);
            t_in     = S_C9;
            pc_in    = 2'd0;
            state_in = CS_POLY;
         end
         CS_POLY: begin
            t_in  = poly_coef(pc_ff) - 32'((63'(z2_ff) * 63'(t_ff)) >> 30);
            pc_in = pc_ff + 2'd1;
            if (pc_ff == 2'd3) begin
               state_in = CS_SINE;
            end
         end
         CS_SINE: begin
            if (cos_sel_ff) begin
               cm_in    = ymag;
               cneg_in  = zneg_ff;
               state_in = CS_MUL0;
            end else begin
               sm_in      = ymag;
               sneg_in    = zneg_ff;
               cos_sel_in = 1'b1;
               state_in   = CS_FOLD;
            end
         end
         CS_MUL0: begin
            pm_in    = 30'((64'(amp_ff) * 64'(sm_ff) + 64'h2_0000_0000) >> 34);
            p_in     = 33'((64'(amp_ff) * 64'(cm_ff) + 64'h2000_0000) >> 30);
            state_in = CS_Q;
         end
         CS_Q: begin
            q_in     = 41'((49'(p_ff) * 49'(f_ff)) >> 8);
            state_in = CS_VM;
         end
         CS_VM: begin
            vm_in    = 37'((65'(q_ff) * 65'(TWOPI_Q20) + 65'h800_0000) >> 28);
            state_in = CS_OUT;
         end
         CS_OUT: begin
            pos_in   = sat32(39'(pw));
            vel_in   = sat32(vw);
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign done         = done_ff;
   assign rsp.samp     = samp_ff;
   assign rsp.sphase   = sph_ff;
   assign rsp.afreq    = f_ff;
   assign rsp.position = pos_ff;
   assign rsp.velocity = vel_ff;

endmodule

// ===== design/six_axis_sine_motion_generator_top.sv =====
// Six-axis sine motion generator: axis state memories, tick sequencer and result register.
//
//   Channel  Ports   Carries
//   input    req_*   one op: set targets, tick, or restore defaults
//   output   rsp_*   one result per axis for each tick, yaw result marked last
//   config   csr_*   heave_bias (index 0), run_enable (index 1)
//
// Set and restore ops are taken in the idle state and do not stall the input. A tick holds
// the input stalled while each axis reads its state memories, runs through the shared
// sequential arithmetic unit (two polynomial sine evaluations dominate) and writes back.
// Reset is synchronous; the default targets and cleared state are given by valid bits.
// A stalled result only holds up the sequencer when the next axis result is ready.
module six_axis_sine_motion_generator_top import smg_pkg::*; #(
   parameter int AXES = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [2:0]         req_axis,
   input  logic [23:0]        req_amp_target,
   input  logic signed [15:0] req_phase_target,
   input  logic [15:0]        req_freq_target,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_axis,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [20:0]        csr_wdata
);

   localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

   top_state_type state_ff, state_in;
   logic [AW-1:0]      ax_ff, ax_in;
   logic [18:0]        nm_ff, nm_in;
   logic               any_amp_ff, any_amp_in;
   logic [31:0]        tick_ff, tick_in;
   logic               run_en_ff, run_en_in;
   logic [20:0]        bias_ff, bias_in;
   logic [AXES-1:0]    tgt_vld_ff, tgt_vld_in, st_vld_ff, st_vld_in;
   calc_req_type       creq_ff, creq_in;
   logic               start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_axis_ff, rsp_axis_in;
   logic signed [31:0] rsp_pos_ff, rsp_pos_in, rsp_vel_ff, rsp_vel_in;
   logic               rsp_last_ff, rsp_last_in;

   logic          tgt_we, st_we;
   logic [AW-1:0] req_idx;
   logic [55:0]   tgt_rd;
   logic [71:0]   st_rd;
   logic          calc_done;
   calc_rsp_type  crsp;
   logic [39:0]   nh_prod;
   logic [4:0]    nh_rem;

   assign req_idx = AW'(req_axis);

   smg_ram #(.WIDTH(56), .DEPTH(AXES)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (req_idx),
      .wr_data ({req_amp_target, req_phase_target, req_freq_target}),
      .rd_addr (ax_ff),
      .rd_data (tgt_rd)
   );

   smg_ram #(.WIDTH(72), .DEPTH(AXES)) u_st_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (ax_ff),
      .wr_data ({crsp.samp, crsp.sphase, crsp.afreq}),
      .rd_addr (ax_ff),
      .rd_data (st_rd)
   );

   smg_axis_calc u_calc (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .req   (creq_ff),
      .done  (calc_done),
      .rsp   (crsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         tick_ff      <= '0;
         run_en_ff    <= 1'b1;
         bias_ff      <= HEAVE_BIAS_RST;
         tgt_vld_ff   <= '0;
         st_vld_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         run_en_ff    <= run_en_in;
         bias_ff      <= bias_in;
         tgt_vld_ff   <= tgt_vld_in;
         st_vld_ff    <= st_vld_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      nm_ff       <= nm_in;
      any_amp_ff  <= any_amp_in;
      creq_ff     <= creq_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      nm_in        = nm_ff;
      any_amp_in   = any_amp_ff;
      tick_in      = tick_ff;
      run_en_in    = run_en_ff;
      bias_in      = bias_ff;
      tgt_vld_in   = tgt_vld_ff;
      st_vld_in    = st_vld_ff;
      creq_in      = creq_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_last_in  = rsp_last_ff;
      tgt_we       = 1'b0;
      st_we        = 1'b0;

      // Tick count reduced modulo 409600 once per tick.
      nh_prod = 40'(tick_ff[31:14]) * 40'(MOD25_M26);
      nh_rem  = 5'(tick_ff[31:14] - 18'(32'(nh_prod[39:26]) * 32'd25));

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEAVE_BIAS: bias_in   = csr_wdata;
            CSR_RUN_ENABLE: run_en_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         TS_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_SET: begin
                     if (32'(req_axis) < AXES) begin
                        tgt_we              = 1'b1;
                        tgt_vld_in[req_idx] = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     state_in = TS_PREP;
                  end
                  OP_DEFAULTS: begin
                     tgt_vld_in = '0;
                     tick_in    = '0;
                     run_en_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         TS_PREP: begin
            nm_in      = {nh_rem, tick_ff[13:0]};
            ax_in      = '0;
            any_amp_in = 1'b0;
            state_in   = TS_READ;
         end
         TS_READ: begin
            state_in = TS_LOAD;
         end
         TS_LOAD: begin
            // An entry never written reads as its reset value.
            if (tgt_vld_ff[ax_ff]) begin
               creq_in.tamp   = tgt_rd[55:32];
               creq_in.tphase = tgt_rd[31:16];
               creq_in.tfreq  = tgt_rd[15:0];
            end else begin
               creq_in.tamp   = '0;
               creq_in.tphase = def_phase(32'(ax_ff));
               creq_in.tfreq  = def_freq(32'(ax_ff));
            end
            if (st_vld_ff[ax_ff]) begin
               creq_in.samp   = st_rd[71:40];
               creq_in.sphase = st_rd[39:16];
               creq_in.afreq  = st_rd[15:0];
            end else begin
               creq_in.samp   = '0;
               creq_in.sphase = '0;
               creq_in.afreq  = def_freq(32'(ax_ff));
            end
            creq_in.angular = (32'(ax_ff) >= 3);
            creq_in.heave   = (32'(ax_ff) == 2);
            creq_in.n_le1   = (tick_ff <= 32'd1);
            creq_in.nm      = nm_ff;
            creq_in.bias    = bias_ff;
            any_amp_in      = any_amp_ff || (creq_in.tamp != 24'd0);
            start_in        = 1'b1;
            state_in        = TS_RUN;
         end
         TS_RUN: begin
            if (calc_done) begin
               state_in = TS_PUT;
            end
         end
         TS_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_axis_in      = 3'(ax_ff);
               rsp_pos_in       = crsp.position;
               rsp_vel_in       = crsp.velocity;
               rsp_last_in      = (ax_ff == AW'(AXES - 1));
               st_we            = 1'b1;
               st_vld_in[ax_ff] = 1'b1;
               if (ax_ff == AW'(AXES - 1)) begin
                  if (run_en_ff && any_amp_ff) begin
                     tick_in = tick_ff + 32'd1;
                  end
                  state_in = TS_IDLE;
               end else begin
                  ax_in    = ax_ff + AW'(1);
                  state_in = TS_READ;
               end
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   assign req_stall    = (state_ff != TS_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_axis = rsp_axis_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_velocity = rsp_vel_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== design/smg_checker.sv =====
// Port-level checks of the motion generator, bound to the top level.
`include "six_axis_sine_motion_generator_top_defines.svh"

module smg_checker import smg_pkg::*; #(
   parameter int AXES = 6
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_op,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_out_axis,
   input logic signed [31:0] rsp_position,
   input logic signed [31:0] rsp_velocity,
   input logic               rsp_last
);

   logic        rsp_wait;
   logic        tick_acc;
   logic        last_axis;
   logic [68:0] rsp_item;

   assign rsp_wait  = rsp_valid && rsp_stall;
   assign tick_acc  = req_valid && !req_stall && (req_op == OP_TICK);
   assign last_axis = (rsp_out_axis == 3'(AXES - 1));
   assign rsp_item  = {rsp_valid, rsp_out_axis, rsp_position, rsp_velocity, rsp_last};

   // A waiting result item keeps its payload.
   `SMG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_item), "stalled item changed")

   // An accepted tick makes the block busy on the next cycle.
   `SMG_ASSERT_NEXT(a_tick_busy, clock, reset, tick_acc, req_stall, "not busy after a tick")

   // The item that closes a tick belongs to the final axis.
   `SMG_ASSERT_NOW(a_last_axis, clock, reset, rsp_valid && rsp_last, last_axis, "last on wrong axis")

   // Result items are only produced while a tick is in progress.
   `SMG_ASSERT_NOW(a_rsp_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "item outside a tick")

endmodule

bind six_axis_sine_motion_generator_top smg_checker #(.AXES(AXES)) u_smg_checker (.*);
